[hw/rtl/ogg_pd_pkg.sv]
// ----------------------------------------------------------------------------
// Ogg page deframer package
// Phase codes, status codes, header byte positions and shared structs.
// ----------------------------------------------------------------------------
package ogg_pd_pkg;

	typedef enum logic [2:0] {
		PH_CAPTURE = 3'd0,
		PH_HEADER  = 3'd1,
		PH_LACING  = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_ERROR   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		ST_PAYLOAD     = 2'd0,
		ST_BAD_CAPTURE = 2'd1,
		ST_NO_BOS      = 2'd2
	} status_t;

	localparam logic [4:0] HDR_TYPE_POS = 5'd5;
	localparam logic [4:0] SERIAL_FIRST = 5'd14;
	localparam logic [4:0] SERIAL_LAST  = 5'd17;
	localparam logic [4:0] SEGCOUNT_POS = 5'd26;
	localparam logic [4:0] HEADER_START = 5'd4;
	localparam int         BOS_BIT      = 1;

	typedef struct packed {
		logic        valid;
		logic [7:0]  payload_byte;
		status_t     status;
		logic        page_end;
	} result_t;

	typedef struct packed {
		logic errored;
		logic in_payload;
	} pd_stat_t;

	// "OggS"
	function automatic logic [7:0] capture_byte(input logic [1:0] idx);
		logic [7:0] b;
		unique case (idx)
			2'd0: b = 8'h4F;
			2'd1: b = 8'h67;
			2'd2: b = 8'h67;
			2'd3: b = 8'h53;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

[hw/rtl/ogg_pd_parser.sv]
// ----------------------------------------------------------------------------
// Ogg page parser core
// Header state machine: updates page state on each accepted beat and gives
// the combinational result for that beat.
// ----------------------------------------------------------------------------
module ogg_pd_parser
	import ogg_pd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       beat_valid,
	input  logic [7:0] data_byte,
	input  logic       discard,
	input  logic       lock_to_stream,
	output result_t    res,
	output pd_stat_t   stat
);

	phase_t      phase_q, phase_d;
	logic [4:0]  header_pos_q, header_pos_d;
	logic [7:0]  header_type_q, header_type_d;
	logic [31:0] serial_q, serial_d;
	logic [31:0] locked_serial_q, locked_serial_d;
	logic [7:0]  lacing_left_q, lacing_left_d;
	logic [15:0] payload_left_q, payload_left_d;
	logic        skip_page_q, skip_page_d;

	logic        decide;
	logic [15:0] total;
	logic        foreign;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_CAPTURE;
			header_pos_q    <= '0;
			header_type_q   <= '0;
			serial_q        <= '0;
			locked_serial_q <= '0;
			lacing_left_q   <= '0;
			payload_left_q  <= '0;
			skip_page_q     <= 1'b0;
		end else if (beat_valid) begin
			phase_q         <= phase_d;
			header_pos_q    <= header_pos_d;
			header_type_q   <= header_type_d;
			serial_q        <= serial_d;
			locked_serial_q <= locked_serial_d;
			lacing_left_q   <= lacing_left_d;
			payload_left_q  <= payload_left_d;
			skip_page_q     <= skip_page_d;
		end
	end

	assign foreign = serial_q != locked_serial_q;

	always_comb begin
		phase_d         = phase_q;
		header_pos_d    = header_pos_q;
		header_type_d   = header_type_q;
		serial_d        = serial_q;
		locked_serial_d = locked_serial_q;
		lacing_left_d   = lacing_left_q;
		payload_left_d  = payload_left_q;
		skip_page_d     = skip_page_q;
		decide          = 1'b0;
		total           = '0;
		res             = '0;
		res.status      = ST_PAYLOAD;

		unique case (phase_q)
			PH_CAPTURE: begin
				if (data_byte != capture_byte(header_pos_q[1:0])) begin
					phase_d    = PH_ERROR;
					res.valid  = 1'b1;
					res.status = ST_BAD_CAPTURE;
				end else if (header_pos_q[1:0] == 2'd3) begin
					header_pos_d = HEADER_START;
					phase_d      = PH_HEADER;
				end else begin
					header_pos_d = {3'd0, header_pos_q[1:0] + 2'd1};
				end
			end
			PH_HEADER: begin
				if (header_pos_q == HDR_TYPE_POS)
					header_type_d = data_byte;
				if (header_pos_q >= SERIAL_FIRST && header_pos_q <= SERIAL_LAST)
					serial_d = {data_byte, serial_q[31:8]};
				if (header_pos_q >= SEGCOUNT_POS) begin
					lacing_left_d  = data_byte;
					payload_left_d = '0;
					if (data_byte == 8'd0)
						decide = 1'b1;
					else
						phase_d = PH_LACING;
				end else begin
					header_pos_d = header_pos_q + 5'd1;
				end
			end
			PH_LACING: begin
				total          = payload_left_q + {8'd0, data_byte};
				payload_left_d = total;
				lacing_left_d  = lacing_left_q - 8'd1;
				if (lacing_left_d == 8'd0)
					decide = 1'b1;
			end
			PH_PAYLOAD: begin
				payload_left_d = payload_left_q - 16'd1;
				if (payload_left_d == 16'd0) begin
					phase_d      = PH_CAPTURE;
					header_pos_d = '0;
				end
				if (!skip_page_q && !discard) begin
					res.valid        = 1'b1;
					res.payload_byte = data_byte;
					res.page_end     = payload_left_d == 16'd0;
				end
			end
			PH_ERROR: begin
				phase_d = PH_ERROR;
			end
			default: begin
				phase_d = PH_ERROR;
			end
		endcase

		// lacing complete: accept, skip or reject the page
		if (decide) begin
			if (!lock_to_stream && !header_type_q[BOS_BIT]) begin
				phase_d    = PH_ERROR;
				res.valid  = 1'b1;
				res.status = ST_NO_BOS;
			end else begin
				skip_page_d = lock_to_stream && foreign;
				if (!skip_page_d)
					locked_serial_d = serial_q;
				if (total == 16'd0) begin
					phase_d      = PH_CAPTURE;
					header_pos_d = '0;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
		end
	end

	assign stat.errored    = phase_q == PH_ERROR;
	assign stat.in_payload = phase_q == PH_PAYLOAD;

endmodule

[hw/rtl/ogg_page_deframer.sv]
// ----------------------------------------------------------------------------
// Ogg page deframer
// Parses Ogg pages from a byte stream and passes on the payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one byte of the Ogg file per beat; s_tuser marks a
//   payload byte to be dropped (seek). Master stream m_*: one payload byte
//   per beat, m_tlast on the last byte of a page, m_tuser carries a status
//   code (payload, bad capture pattern, missing beginning-of-stream flag).
//   cfg_wen/cfg_wdata write lock_to_stream; write it only while idle.
//   Each input beat is parsed combinationally; a result, if any, shows on
//   m_* in the cycle after its input beat is taken. One beat per cycle is
//   sustained with m_tready high: the output register refills as it empties.
//   When the receiver stalls, the held result blocks s_tready only while a
//   result is waiting and m_tready is low; beats causing no result still
//   need the output register free, as the decision is made at accept.
//   Reset clears the parser to expect a capture pattern, unlocks the
//   stream and empties the output register. After an error beat the block
//   swallows all input without output until reset.
// ----------------------------------------------------------------------------
module ogg_page_deframer
	import ogg_pd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic [0:0] s_tuser,   // [0] discard
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] payload_byte
	output logic [1:0] m_tuser,   // [1:0] status
	output logic       m_tlast,
	input  logic       cfg_wen,
	input  logic       cfg_wdata
);

	logic     lock_to_stream_q;
	logic     accept;
	result_t  res;
	pd_stat_t stat;
	logic     out_valid_q;
	logic [7:0] out_data_q;
	status_t  out_status_q;
	logic     out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			lock_to_stream_q <= 1'b0;
		else if (cfg_wen)
			lock_to_stream_q <= cfg_wdata;
	end

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	ogg_pd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.beat_valid    (accept),
		.data_byte     (s_tdata),
		.discard       (s_tuser[0]),
		.lock_to_stream(lock_to_stream_q),
		.res           (res),
		.stat          (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold payload while stalled
	always_ff @(posedge clk) begin
		if (accept && res.valid) begin
			out_data_q   <= res.payload_byte;
			out_status_q <= res.status;
			out_last_q   <= res.page_end;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stat.errored |=> stat.errored)
		else $error("error state left without reset");

	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		stat.errored |-> !res.valid)
		else $error("result produced after error");

	a_err_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res.valid && res.status != ST_PAYLOAD) |=> stat.errored)
		else $error("error beat did not enter error state");

	a_last_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tuser == ST_PAYLOAD))
		else $error("page end flagged on an error beat");
`endif

endmodule
